// ===== rtl/epd_pkg.sv =====
package epd_pkg;

   localparam int GAIN_BITS     = 16;
   localparam int DIM_BITS      = 11;
   localparam int WEIGHT_BITS   = 16;
   localparam int NUM_CHANNELS  = 3;
   localparam int NUM_TAPS      = 9;
   localparam int TAP_SUM_BITS  = 4;
   localparam int STEP_BITS     = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // Three pipeline stages sit between a tap being issued and its accumulation.
   localparam int LAST_STEP = NUM_TAPS + 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_EDGE_GAIN    = 2'd0,
      REG_LINE_WIDTH   = 2'd1,
      REG_FRAME_HEIGHT = 2'd2
   } csr_index_type;

   localparam logic [GAIN_BITS-1:0] EDGE_GAIN_RESET    = 16'd3840;
   localparam logic [DIM_BITS-1:0]  LINE_WIDTH_RESET   = 11'd640;
   localparam logic [DIM_BITS-1:0]  FRAME_HEIGHT_RESET = 11'd480;

endpackage

// ===== rtl/epd_req_if.sv =====
interface epd_req_if #(
   parameter int CHANNEL_BITS = 16
);
   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic [CHANNEL_BITS-1:0] red_in;
   logic [CHANNEL_BITS-1:0] green_in;
   logic [CHANNEL_BITS-1:0] blue_in;

   modport source (output valid, kind, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

// ===== rtl/epd_rsp_if.sv =====
interface epd_rsp_if #(
   parameter int CHANNEL_BITS = 16
);
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] red_out;
   logic [CHANNEL_BITS-1:0] green_out;
   logic [CHANNEL_BITS-1:0] blue_out;
   logic                    last_pixel;

   modport source (output valid, red_out, green_out, blue_out, last_pixel, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, last_pixel, output ready);
endinterface

// ===== rtl/edge_preserving_diffusion_3x3.sv =====
// Each item runs in steps: a pixel or drain item is accepted and the two line stores are read,
// then the window is updated; an item that gives no result is done there (a kind item before
// the last rows is done on acceptance). An item that gives a result then runs the three channel
// lanes through weighting and bit-serial division and hands over to the output register, waiting
// while that register holds an untaken result; the item that ends a frame skips the window update.
// A new item is taken only once the last is done; the output register holds a result while the next goes in.
// Synchronous active-high reset clears state, counters, window, CSRs and output valid; line stores need no clearing.
module edge_preserving_diffusion_3x3 #(
   parameter int MAX_WIDTH       = 1024,
   parameter int CHANNEL_BITS    = 16,
   parameter int EXP_TABLE_DEPTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [epd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [epd_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   epd_req_if.sink                            req_chan,
   epd_rsp_if.source                          rsp_chan
);

   localparam int PIX_BITS = epd_pkg::NUM_CHANNELS * CHANNEL_BITS;
   localparam int CW       = $clog2(MAX_WIDTH);
   localparam int RW       = epd_pkg::DIM_BITS + 1;
   localparam int CMP      = (CW + 1 > epd_pkg::DIM_BITS) ? CW + 1 : epd_pkg::DIM_BITS;
   localparam int NT       = epd_pkg::NUM_TAPS;

   typedef logic [PIX_BITS-1:0] pix_type;
   typedef enum logic [1:0] {S_IDLE, S_LOAD, S_FILTER} state_type;

   state_type                        state_ff, state_in;
   logic [epd_pkg::GAIN_BITS-1:0]    edge_gain_ff;
   logic [epd_pkg::DIM_BITS-1:0]     line_width_ff, frame_height_ff;
   logic [CW-1:0]                    col_ff, col_in;
   logic [RW-1:0]                    row_ff, row_in;
   pix_type                          win_ff [3][3];
   pix_type                          win_in [3][3];
   pix_type                          pix_ff;
   logic                             drain_ff;
   pix_type                          rd_up_ff, rd_mid_ff;
   pix_type                          tap_ff [NT];
   pix_type                          tap_in [NT];
   logic                             last_ff, last_in;
   logic                             rsp_valid_ff;
   logic [CHANNEL_BITS-1:0]          red_ff, green_ff, blue_ff;
   logic                             rsp_last_ff;

   pix_type                          upper_mem  [MAX_WIDTH];
   pix_type                          middle_mem [MAX_WIDTH];

   logic [CMP-1:0]                   width_eff;
   logic [RW-1:0]                    height_eff;
   logic                             accept;
   logic                             go_filter;
   logic                             mem_write;
   pix_type                          new_col [3];
   logic                             lanes_done;
   logic                             rsp_load;
   logic [CHANNEL_BITS-1:0]          lane_result [epd_pkg::NUM_CHANNELS];
   logic                             lane_done [epd_pkg::NUM_CHANNELS];
   logic [CHANNEL_BITS-1:0]          lane_taps [epd_pkg::NUM_CHANNELS][NT];
   logic [CHANNEL_BITS-1:0]          lane_centre [epd_pkg::NUM_CHANNELS];
   pix_type                          centre_ff, centre_in;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      if (line_width_ff == '0) begin
         width_eff = CMP'(1);
      end else if (CMP'(line_width_ff) > CMP'(MAX_WIDTH)) begin
         width_eff = CMP'(MAX_WIDTH);
      end else begin
         width_eff = CMP'(line_width_ff);
      end
      height_eff = (frame_height_ff == '0) ? RW'(1) : RW'(frame_height_ff);
   end

   // New window column: rows above the centre replicate the first row, and rows
   // beyond the frame replicate the last one.
   always_comb begin
      if (row_ff == '0) begin
         new_col[0] = pix_ff;
         new_col[1] = pix_ff;
         new_col[2] = pix_ff;
      end else begin
         new_col[1] = rd_mid_ff;
         new_col[0] = (row_ff == RW'(1)) ? rd_mid_ff : rd_up_ff;
         new_col[2] = drain_ff ? rd_mid_ff : pix_ff;
      end
   end

   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      win_in    = win_ff;
      tap_in    = tap_ff;
      centre_in = centre_ff;
      last_in   = last_ff;
      go_filter = 1'b0;
      mem_write = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (row_ff > height_eff) begin
                  // End of frame: right edge of the bottom row, then restart.
                  for (int ci = 0; ci < 3; ci++) begin
                     for (int ri = 0; ri < 3; ri++) begin
                        tap_in[ci*3+ri] = win_ff[(ci == 0) ? 1 : 2][ri];
                     end
                  end
                  centre_in = win_ff[2][1];
                  last_in   = 1'b1;
                  col_in    = '0;
                  row_in    = '0;
                  go_filter = 1'b1;
                  state_in  = S_FILTER;
               end else if (!(req_chan.kind && row_ff < height_eff)) begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            mem_write = !drain_ff;
            last_in   = 1'b0;
            if (col_ff == '0) begin
               // Start of a row: the previous row's right edge uses the old window.
               for (int ci = 0; ci < 3; ci++) begin
                  for (int ri = 0; ri < 3; ri++) begin
                     tap_in[ci*3+ri] = win_ff[(ci == 0) ? 1 : 2][ri];
                     win_in[ci][ri]  = new_col[ri];
                  end
               end
               centre_in = win_ff[2][1];
               go_filter = (row_ff >= RW'(2));
            end else begin
               for (int ri = 0; ri < 3; ri++) begin
                  win_in[0][ri] = win_ff[1][ri];
                  win_in[1][ri] = win_ff[2][ri];
                  win_in[2][ri] = new_col[ri];
               end
               for (int ci = 0; ci < 3; ci++) begin
                  for (int ri = 0; ri < 3; ri++) begin
                     tap_in[ci*3+ri] = win_in[ci][ri];
                  end
               end
               centre_in = win_ff[2][1];
               go_filter = (row_ff >= RW'(1));
            end
            if (CMP'(col_ff) + CMP'(1) >= width_eff) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
            state_in = go_filter ? S_FILTER : S_IDLE;
         end
         S_FILTER: begin
            if (lanes_done && (!rsp_valid_ff || rsp_chan.ready)) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         col_ff          <= '0;
         row_ff          <= '0;
         last_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         edge_gain_ff    <= epd_pkg::EDGE_GAIN_RESET;
         line_width_ff   <= epd_pkg::LINE_WIDTH_RESET;
         frame_height_ff <= epd_pkg::FRAME_HEIGHT_RESET;
         for (int ci = 0; ci < 3; ci++) begin
            for (int ri = 0; ri < 3; ri++) begin
               win_ff[ci][ri] <= '0;
            end
         end
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         win_ff   <= win_in;
         last_ff  <= last_in;
         if (csr_we) begin
            unique case (csr_index)
               epd_pkg::REG_EDGE_GAIN:    edge_gain_ff    <= csr_wdata;
               epd_pkg::REG_LINE_WIDTH:   line_width_ff   <= csr_wdata[epd_pkg::DIM_BITS-1:0];
               epd_pkg::REG_FRAME_HEIGHT: frame_height_ff <= csr_wdata[epd_pkg::DIM_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      tap_ff    <= tap_in;
      centre_ff <= centre_in;
      if (accept) begin
         pix_ff   <= {req_chan.blue_in, req_chan.green_in, req_chan.red_in};
         drain_ff <= (row_ff >= height_eff);
      end
      if (rsp_load) begin
         red_ff      <= lane_result[0];
         green_ff    <= lane_result[1];
         blue_ff     <= lane_result[2];
         rsp_last_ff <= last_ff;
      end
   end

   // Line stores: read when an item is taken, written back in the next cycle for a pixel item.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_up_ff  <= upper_mem[col_ff];
         rd_mid_ff <= middle_mem[col_ff];
      end
      if (mem_write) begin
         upper_mem[col_ff]  <= rd_mid_ff;
         middle_mem[col_ff] <= new_col[2];
      end
   end

   for (genvar ch = 0; ch < epd_pkg::NUM_CHANNELS; ch++) begin : g_lane
      for (genvar k = 0; k < NT; k++) begin : g_tap
         assign lane_taps[ch][k] = tap_ff[k][ch*CHANNEL_BITS +: CHANNEL_BITS];
      end
      assign lane_centre[ch] = centre_ff[ch*CHANNEL_BITS +: CHANNEL_BITS];

      epd_lane #(
         .CHANNEL_BITS    (CHANNEL_BITS),
         .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .start     (go_filter),
         .edge_gain (edge_gain_ff),
         .centre    (lane_centre[ch]),
         .taps      (lane_taps[ch]),
         .done      (lane_done[ch]),
         .result    (lane_result[ch])
      );
   end

   assign lanes_done = lane_done[0] && lane_done[1] && lane_done[2];

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.red_out    = red_ff;
   assign rsp_chan.green_out  = green_ff;
   assign rsp_chan.blue_out   = blue_ff;
   assign rsp_chan.last_pixel = rsp_last_ff;

endmodule

// ===== rtl/epd_lane.sv =====
module epd_lane #(
   parameter int CHANNEL_BITS    = 16,
   parameter int EXP_TABLE_DEPTH = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [epd_pkg::GAIN_BITS-1:0]  edge_gain,
   input  logic [CHANNEL_BITS-1:0]        centre,
   input  logic [CHANNEL_BITS-1:0]        taps [epd_pkg::NUM_TAPS],
   output logic                           done,
   output logic [CHANNEL_BITS-1:0]        result
);

   localparam int LOG_DEPTH  = $clog2(EXP_TABLE_DEPTH);
   localparam int PROD_BITS  = epd_pkg::GAIN_BITS + CHANNEL_BITS;
   localparam int SHIFT      = 12 + CHANNEL_BITS - LOG_DEPTH;
   localparam int IDX_BITS   = PROD_BITS - SHIFT;
   localparam int WPROD_BITS = epd_pkg::WEIGHT_BITS + CHANNEL_BITS;
   localparam int NW         = WPROD_BITS + epd_pkg::TAP_SUM_BITS;
   localparam int DW         = epd_pkg::WEIGHT_BITS + epd_pkg::TAP_SUM_BITS;
   localparam int DIV_CNT_BITS = $clog2(NW + 1);
   localparam int TAP_IDX_BITS = $clog2(epd_pkg::NUM_TAPS);

   // Base of the table, exp(-16/depth) in Q0.32, as a truncated Taylor series.
   localparam longint unsigned T1  = (64'd1 << 32) * 16 / (64'(EXP_TABLE_DEPTH) * 1);
   localparam longint unsigned T2  = T1  * 16 / (64'(EXP_TABLE_DEPTH) * 2);
   localparam longint unsigned T3  = T2  * 16 / (64'(EXP_TABLE_DEPTH) * 3);
   localparam longint unsigned T4  = T3  * 16 / (64'(EXP_TABLE_DEPTH) * 4);
   localparam longint unsigned T5  = T4  * 16 / (64'(EXP_TABLE_DEPTH) * 5);
   localparam longint unsigned T6  = T5  * 16 / (64'(EXP_TABLE_DEPTH) * 6);
   localparam longint unsigned T7  = T6  * 16 / (64'(EXP_TABLE_DEPTH) * 7);
   localparam longint unsigned T8  = T7  * 16 / (64'(EXP_TABLE_DEPTH) * 8);
   localparam longint unsigned T9  = T8  * 16 / (64'(EXP_TABLE_DEPTH) * 9);
   localparam longint unsigned T10 = T9  * 16 / (64'(EXP_TABLE_DEPTH) * 10);
   localparam longint unsigned T11 = T10 * 16 / (64'(EXP_TABLE_DEPTH) * 11);
   localparam longint unsigned T12 = T11 * 16 / (64'(EXP_TABLE_DEPTH) * 12);
   localparam longint unsigned BASE_RAW = (64'd1 << 32) - T1 + T2 - T3 + T4 - T5 + T6
                                          - T7 + T8 - T9 + T10 - T11 + T12;
   localparam longint unsigned BASE = (BASE_RAW > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : BASE_RAW;

   typedef logic [epd_pkg::WEIGHT_BITS-1:0] table_type [EXP_TABLE_DEPTH];

   function automatic table_type build_table(input logic [63:0] base);
      table_type   tab;
      logic [63:0] v;
      logic [63:0] t;
      v = 64'd1 << 31;
      for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
         t = (v + (64'd1 << 14)) >> 15;
         tab[i] = (t > 64'd65535) ? 16'hFFFF : t[15:0];
         v = (v * base + (64'd1 << 31)) >> 32;
      end
      return tab;
   endfunction

   localparam table_type EXP_TABLE = build_table(BASE);

   typedef enum logic [1:0] {L_IDLE, L_RUN, L_DIV, L_DONE} lane_state_type;

   lane_state_type                      state_ff;
   logic [epd_pkg::STEP_BITS-1:0]       step_ff;
   logic                                s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic [PROD_BITS-1:0]                s1_prod_ff;
   logic [CHANNEL_BITS-1:0]             s1_q_ff, s2_q_ff;
   logic [epd_pkg::WEIGHT_BITS-1:0]     s2_w_ff, s3_w_ff;
   logic                                s2_zero_ff;
   logic [WPROD_BITS-1:0]               s3_prod_ff;
   logic [NW-1:0]                       num_ff, dividend_ff;
   logic [DW-1:0]                       den_ff, rem_ff;
   logic [CHANNEL_BITS:0]               quot_ff;
   logic                                ovf_ff;
   logic [DIV_CNT_BITS-1:0]             div_cnt_ff;

   logic [TAP_IDX_BITS-1:0]             tap_idx;
   logic [CHANNEL_BITS-1:0]             tap;
   logic [CHANNEL_BITS-1:0]             diff;
   logic [IDX_BITS-1:0]                 idx_full;
   logic [epd_pkg::WEIGHT_BITS-1:0]     weight;
   logic [DW:0]                         trial;
   logic                                trial_ge;
   logic [DW:0]                         trial_sub;

   always_comb begin
      tap_idx   = (step_ff < epd_pkg::STEP_BITS'(epd_pkg::NUM_TAPS)) ?
                  step_ff[TAP_IDX_BITS-1:0] : '0;
      tap       = taps[tap_idx];
      diff      = (centre > tap) ? (centre - tap) : (tap - centre);
      idx_full  = s1_prod_ff[PROD_BITS-1:SHIFT];
      weight    = s2_zero_ff ? '0 : s2_w_ff;
      trial     = {rem_ff, dividend_ff[NW-1]};
      trial_ge  = trial >= {1'b0, den_ff};
      trial_sub = trial - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= L_IDLE;
         step_ff   <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= (state_ff == L_RUN) &&
                      (step_ff < epd_pkg::STEP_BITS'(epd_pkg::NUM_TAPS));
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         unique case (state_ff)
            L_IDLE, L_DONE: begin
               if (start) begin
                  state_ff <= L_RUN;
                  step_ff  <= '0;
                  num_ff   <= '0;
                  den_ff   <= '0;
               end
            end
            L_RUN: begin
               step_ff <= step_ff + 1'b1;
               if (s3_vld_ff) begin
                  num_ff <= num_ff + NW'(s3_prod_ff);
                  den_ff <= den_ff + DW'(s3_w_ff);
               end
               if (step_ff == epd_pkg::STEP_BITS'(epd_pkg::LAST_STEP)) begin
                  state_ff    <= L_DIV;
                  dividend_ff <= num_ff + NW'(den_ff >> 1);
                  rem_ff      <= '0;
                  quot_ff     <= '0;
                  ovf_ff      <= 1'b0;
                  div_cnt_ff  <= '0;
               end
            end
            L_DIV: begin
               dividend_ff <= dividend_ff << 1;
               rem_ff      <= trial_ge ? trial_sub[DW-1:0] : trial[DW-1:0];
               quot_ff     <= {quot_ff[CHANNEL_BITS-1:0], trial_ge};
               ovf_ff      <= ovf_ff | quot_ff[CHANNEL_BITS];
               div_cnt_ff  <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == DIV_CNT_BITS'(NW - 1)) begin
                  state_ff <= L_DONE;
               end
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   // Weight pipeline: distance and gain product, table look-up, weighted value.
   always_ff @(posedge clock) begin
      s1_prod_ff <= edge_gain * diff;
      s1_q_ff    <= tap;
      s2_zero_ff <= idx_full >= IDX_BITS'(EXP_TABLE_DEPTH);
      s2_w_ff    <= EXP_TABLE[idx_full[LOG_DEPTH-1:0]];
      s2_q_ff    <= s1_q_ff;
      s3_prod_ff <= weight * s2_q_ff;
      s3_w_ff    <= weight;
   end

   assign done   = (state_ff == L_DONE);
   assign result = (ovf_ff || quot_ff[CHANNEL_BITS]) ? '1 : quot_ff[CHANNEL_BITS-1:0];

endmodule
